/* hdl/aesd_pkg.sv */
// ----------------------------------------------------------------------------
// AES decrypt package
// Shared constants, types and the inverse S-box for the block decrypter.
// ----------------------------------------------------------------------------
`default_nettype none
package aesd_pkg;
	localparam int unsigned ROUND_KEY_SLOTS = 15;
	localparam int unsigned SLOT_W = 4;
	// Each key half lives in its own bank, one entry per slot.
	localparam int unsigned RAM_DEPTH = ROUND_KEY_SLOTS;
	localparam int unsigned RAM_AW = $clog2(RAM_DEPTH);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	localparam logic [1:0] KSZ_128 = 2'd0;
	localparam logic [1:0] KSZ_192 = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEYHI,
		ST_KEYLO,
		ST_SUB,
		ST_MIX,
		ST_DONE
	} state_t;

	typedef logic [7:0] inv_box_t [256];
	localparam inv_box_t INV_BOX = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// Multiply by x in GF(2^8).
	function automatic logic [7:0] gf2(input logic [7:0] a);
		gf2 = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// One output byte of inverse mix columns: 0e*a ^ 0b*b ^ 0d*c ^ 09*d.
	function automatic logic [7:0] unmix_byte(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic [7:0] d);
		logic [7:0] a2, a4, a8, b2, b4, b8, c2, c4, c8, d2, d4, d8;
		a2 = gf2(a); a4 = gf2(a2); a8 = gf2(a4);
		b2 = gf2(b); b4 = gf2(b2); b8 = gf2(b4);
		c2 = gf2(c); c4 = gf2(c2); c8 = gf2(c4);
		d2 = gf2(d); d4 = gf2(d2); d8 = gf2(d4);
		unmix_byte = (a8 ^ a4 ^ a2) ^ (b8 ^ b2 ^ b) ^ (c8 ^ c4 ^ c) ^ (d8 ^ d);
	endfunction
endpackage
`default_nettype wire

/* hdl/aesd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module aesd_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 30
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* hdl/aes_block_decrypt.sv */
// ----------------------------------------------------------------------------
// AES block decrypt
// Inverse cipher over stored round keys; one byte of the state per cycle in the S-box phase.
// ----------------------------------------------------------------------------
// A round key load is written to the key store when it is accepted. A decrypt
// adds round key Nr (Nr = 10, 12, 14), then for each lower round passes the
// state byte by byte through one S-box lane, reads and adds the round key and
// unmixes the columns one at a time (not after key 0), then offers the result.
// One block is processed at a time: no new transaction is accepted until the
// result is taken. Reset clears control state and the key size register only.
`default_nettype none
module aes_block_decrypt (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// s_tdata: key_slot[3:0], word_high[67:4], word_low[131:68], zero fill
	input  wire logic [135:0] s_tdata,
	// s_tuser: cmd
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// m_tdata: plain_high[63:0], plain_low[127:64]
	output logic      [127:0] m_tdata
);
	aesd_pkg::state_t state_q, state_d;
	logic [1:0] ksz_q;
	logic [3:0] round_q;
	logic [3:0] cnt_q;
	logic [127:0] st_q;
	logic [3:0] nr;
	logic ram_we;
	logic [aesd_pkg::RAM_AW-1:0] waddr, raddr;
	logic [63:0] rk_hi, rk_lo;
	logic [7:0] sb;
	logic [1:0] mixc;
	logic [31:0] col, mcol;

	// Key size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksz_q <= aesd_pkg::KSZ_128;
		end else if (cfg_we) begin
			ksz_q <= cfg_wdata;
		end
	end

	assign nr = (ksz_q == aesd_pkg::KSZ_128) ? 4'd10 :
		(ksz_q == aesd_pkg::KSZ_192) ? 4'd12 : 4'd14;

	// Round key memory: one bank for the high half and one for the low half.
	assign ram_we = s_tvalid && s_tready && (s_tuser == aesd_pkg::CMD_LOAD) &&
		(s_tdata[3:0] < aesd_pkg::SLOT_W'(aesd_pkg::ROUND_KEY_SLOTS));
	assign waddr = aesd_pkg::RAM_AW'(s_tdata[3:0]);
	assign raddr = aesd_pkg::RAM_AW'(round_q);

	aesd_ram #(.WIDTH(64), .DEPTH(aesd_pkg::RAM_DEPTH)) u_ram_hi (
		.clk(clk), .we(ram_we), .waddr(waddr), .wdata(s_tdata[67:4]),
		.raddr(raddr), .rdata(rk_hi)
	);

	aesd_ram #(.WIDTH(64), .DEPTH(aesd_pkg::RAM_DEPTH)) u_ram_lo (
		.clk(clk), .we(ram_we), .waddr(waddr), .wdata(s_tdata[131:68]),
		.raddr(raddr), .rdata(rk_lo)
	);

	// Byte of the state entering the S-box lane: inverse shift rows order.
	// Output byte i = r+4c takes input byte r+4((c-r)&3).
	logic [1:0] r_i, c_i, c_src;
	logic [3:0] src;
	assign r_i = cnt_q[1:0];
	assign c_i = cnt_q[3:2];
	assign c_src = c_i - r_i;
	assign src = {c_src, r_i};
	assign sb = aesd_pkg::INV_BOX[st_q[127 - 8*src -: 8]];

	// Column for inverse mix columns, bytes 0..3 of column mixc.
	assign mixc = cnt_q[1:0];
	assign col = st_q[127 - 32*mixc -: 32];
	assign mcol = {
		aesd_pkg::unmix_byte(col[31:24], col[23:16], col[15:8], col[7:0]),
		aesd_pkg::unmix_byte(col[23:16], col[15:8], col[7:0], col[31:24]),
		aesd_pkg::unmix_byte(col[15:8], col[7:0], col[31:24], col[23:16]),
		aesd_pkg::unmix_byte(col[7:0], col[31:24], col[23:16], col[15:8])};

	// Round key for the current round: zero beyond the store.
	logic [127:0] rk;
	assign rk = (round_q < aesd_pkg::SLOT_W'(aesd_pkg::ROUND_KEY_SLOTS)) ?
		{rk_hi, rk_lo} : 128'd0;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aesd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state. The key read is issued in ST_KEYHI and used in ST_KEYLO.
	always_comb begin
		state_d = state_q;
		case (state_q)
			aesd_pkg::ST_IDLE: begin
				if (s_tvalid && s_tuser == aesd_pkg::CMD_DECRYPT) state_d = aesd_pkg::ST_KEYHI;
			end
			aesd_pkg::ST_KEYHI: state_d = aesd_pkg::ST_KEYLO;
			aesd_pkg::ST_KEYLO: begin
				if (round_q == 4'd0) state_d = aesd_pkg::ST_DONE;
				else if (round_q == nr) state_d = aesd_pkg::ST_SUB;
				else state_d = aesd_pkg::ST_MIX;
			end
			aesd_pkg::ST_MIX: if (cnt_q[1:0] == 2'd3) state_d = aesd_pkg::ST_SUB;
			aesd_pkg::ST_SUB: if (cnt_q == 4'd15) state_d = aesd_pkg::ST_KEYHI;
			aesd_pkg::ST_DONE: if (m_tready) state_d = aesd_pkg::ST_IDLE;
			default: state_d = aesd_pkg::ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == aesd_pkg::ST_IDLE);
	assign m_tvalid = (state_q == aesd_pkg::ST_DONE);
	assign m_tdata = {st_q[63:0], st_q[127:64]};

	// Datapath: key add, byte-serial S-box shift, column-serial unmix.
	logic [119:0] tmp_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				aesd_pkg::ST_IDLE: begin
					round_q <= nr;
					cnt_q <= '0;
				end
				aesd_pkg::ST_KEYLO: cnt_q <= '0;
				aesd_pkg::ST_MIX: cnt_q <= (cnt_q[1:0] == 2'd3) ? 4'd0 : cnt_q + 4'd1;
				aesd_pkg::ST_SUB: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) round_q <= round_q - 4'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			aesd_pkg::ST_IDLE: st_q <= {s_tdata[67:4], s_tdata[131:68]};
			aesd_pkg::ST_KEYLO: st_q <= st_q ^ rk;
			aesd_pkg::ST_MIX: st_q[127 - 32*mixc -: 32] <= mcol;
			aesd_pkg::ST_SUB: begin
				tmp_q <= {tmp_q[111:0], sb};
				if (cnt_q == 4'd15) st_q <= {tmp_q, sb};
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* verif/tb_aes_block_decrypt.sv */
// ----------------------------------------------------------------------------
// AES block decrypt testbench
// Loads round keys and decrypts random and corner-case blocks under every key
// size setting, with random gaps on both streams. A scoreboard recomputes each
// plaintext with its own inverse cipher and checks it against the output.
// ----------------------------------------------------------------------------
`default_nettype none

// Keeps a copy of the round key store and key size, computes the expected
// plaintext of each accepted decrypt and checks the results in order.
class plain_scoreboard;
	logic [7:0] inv_sub [256];
	logic [127:0] round_keys [aesd_pkg::ROUND_KEY_SLOTS];
	logic [1:0] key_size;
	logic [127:0] plain_q [$];
	int unsigned mismatches;
	int unsigned blocks_checked;

	function new();
		logic [7:0] inv, b, fwd;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int y = 1; y < 256; y++) begin
				if (x != 0 && gmul(x[7:0], y[7:0]) == 8'h01)
					inv = y[7:0];
			end
			b = inv;
			fwd = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
				^ {b[3:0], b[7:4]} ^ 8'h63;
			inv_sub[fwd] = x[7:0];
		end
		key_size = aesd_pkg::KSZ_128;
		mismatches = 0;
		blocks_checked = 0;
	endfunction

	// Full multiply in GF(2^8).
	static function logic [7:0] gmul(input logic [7:0] a, input logic [7:0] k);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (k[i])
				acc ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return acc;
	endfunction

	function void set_key_size(input logic [1:0] v);
		key_size = v;
	endfunction

	// Inverse cipher over the held round keys. Byte i sits at row i%4, column i/4.
	function logic [127:0] decrypt(input logic [63:0] hi, input logic [63:0] lo);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] col [4];
		logic [7:0] coef [4];
		logic [127:0] res;
		int nr;
		coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		nr = (key_size == 2'd0) ? 10 : (key_size == 2'd1) ? 12 : 14;
		for (int i = 0; i < 8; i++) begin
			s[i] = hi[63 - 8 * i -: 8];
			s[8 + i] = lo[63 - 8 * i -: 8];
		end
		for (int rnd = nr; rnd >= 0; rnd--) begin
			if (rnd != nr) begin
				for (int r = 0; r < 4; r++)
					for (int c = 0; c < 4; c++)
						t[r + 4 * c] = inv_sub[s[r + 4 * ((c - r + 4) & 3)]];
				s = t;
			end
			for (int i = 0; i < 16; i++)
				s[i] ^= round_keys[rnd][127 - 8 * i -: 8];
			if (rnd != nr && rnd != 0) begin
				for (int c = 0; c < 4; c++) begin
					for (int r = 0; r < 4; r++)
						col[r] = s[r + 4 * c];
					for (int r = 0; r < 4; r++) begin
						s[r + 4 * c] = 8'h00;
						for (int j = 0; j < 4; j++)
							s[r + 4 * c] ^= gmul(col[j], coef[(j - r + 4) & 3]);
					end
				end
			end
		end
		for (int i = 0; i < 8; i++) begin
			res[63 - 8 * i -: 8] = s[i];
			res[127 - 8 * i -: 8] = s[8 + i];
		end
		return res;
	endfunction

	// Notes one accepted input transaction.
	function void note_item(input logic cmd, input logic [3:0] slot,
			input logic [63:0] hi, input logic [63:0] lo);
		if (cmd == aesd_pkg::CMD_LOAD) begin
			if (slot < aesd_pkg::ROUND_KEY_SLOTS)
				round_keys[slot] = {hi, lo};
		end else begin
			plain_q.push_back(decrypt(hi, lo));
		end
	endfunction

	// Checks one accepted output transaction against the oldest expectation.
	function void check_plain(input logic [127:0] got);
		logic [127:0] want;
		if (plain_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected plaintext %h", got);
			return;
		end
		want = plain_q.pop_front();
		blocks_checked++;
		if (got[63:0] !== want[63:0] || got[127:64] !== want[127:64]) begin
			mismatches++;
			if (mismatches <= 10)
				$display("plaintext mismatch: expected high %h low %h, got high %h low %h",
					want[63:0], want[127:64], got[63:0], got[127:64]);
		end
	endfunction
endclass

module tb_aes_block_decrypt;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_wdata = 2'd0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [135:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [127:0] m_tdata;

	plain_scoreboard sb = new();
	bit calm = 1'b0;
	int unsigned idle_cycles = 0;
	int unsigned stall_left = 0;
	int unsigned items_sent = 0;

	aes_block_decrypt dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones, none in calm stretches.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// Output side: random back-pressure, result checking and the watchdog.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_plain(m_tdata);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("DONE: errors detected");
			$finish;
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			m_tready <= 1'b1;
		end
	end

	// Sends one transaction; returns at the edge where it is accepted.
	task automatic send_item(input logic cmd, input logic [3:0] slot,
			input logic [63:0] hi, input logic [63:0] lo);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'b0, lo, hi, slot};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(cmd, slot, hi, lo);
		items_sent++;
	endtask

	// Holds the input off until every result is back and the block has settled.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.plain_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_key_size(input logic [1:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_key_size(v);
	endtask

	function automatic logic [63:0] rand_word();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom(), $urandom()};
	endfunction

	task automatic random_items(input int count);
		logic [3:0] slot;
		for (int n = 0; n < count; n++) begin
			slot = ($urandom_range(0, 19) == 0) ? 4'd15 : 4'($urandom_range(0, 14));
			if ($urandom_range(0, 99) < 40)
				send_item(aesd_pkg::CMD_LOAD, slot, rand_word(), rand_word());
			else
				send_item(aesd_pkg::CMD_DECRYPT, 4'($urandom()), rand_word(), rand_word());
		end
	endtask

	initial begin
		logic [1:0] sizes [8];
		sizes = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1, 2'd3};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: fill every slot, edge values, ignored load, decrypts.
		send_item(aesd_pkg::CMD_LOAD, 4'd0, '0, '0);
		for (int k = 1; k < 14; k++)
			send_item(aesd_pkg::CMD_LOAD, 4'(k), {$urandom(), $urandom()},
				{$urandom(), $urandom()});
		send_item(aesd_pkg::CMD_LOAD, 4'd14, '1, '1);
		send_item(aesd_pkg::CMD_LOAD, 4'd15, {$urandom(), $urandom()},
			{$urandom(), $urandom()});
		send_item(aesd_pkg::CMD_DECRYPT, 4'd0, '0, '0);
		send_item(aesd_pkg::CMD_DECRYPT, 4'd15, '1, '1);
		send_item(aesd_pkg::CMD_DECRYPT, 4'd7, 64'h0123456789abcdef, 64'hfedcba9876543210);
		write_key_size(2'd3);
		send_item(aesd_pkg::CMD_DECRYPT, 4'd0, '1, '0);
		send_item(aesd_pkg::CMD_DECRYPT, 4'd9, '0, '1);

		// Random phases across all key size settings.
		for (int p = 0; p < 8; p++) begin
			write_key_size(sizes[p]);
			calm = (p == 4);
			random_items(100);
			if (p == 2)
				drain_results();
			random_items(100);
		end
		calm = 1'b0;

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.plain_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transactions over every key size code; %0d plaintext blocks checked.",
			items_sent, sb.blocks_checked);
		if (sb.mismatches == 0 && sb.plain_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.plain_q.size());
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

`default_nettype wire
